@@ hdl/nms_pkg.sv @@
// Shared constants, codes and pipeline types for the neighbour mean smoother.
// Depends on nothing; the top level and the testbench use it through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package nms_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int MAX_ROWS   = 4096;
  localparam int NUM_ROWS_W = 13;
  localparam int NUM_COLS_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_CNT_W  = 13;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 10;
  localparam int MEAN_W     = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_BY_3,
    DIV_BY_5,
    DIV_BY_8
  } div_e;

  typedef struct packed {
    logic                 has_out;
    logic                 last;
    logic                 top_ok;
    logic                 bot_ok;
    logic                 left_ok;
    logic                 right_ok;
    div_e                 div;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } meta_t;

endpackage

`default_nettype wire

@@ hdl/nms_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nms_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/neighbour_mean_smoother.sv @@
// Top level of the neighbour mean smoother: counters, line stores, 3x3 window,
// divide by 3, 5 or 8 and output register. Depends on nms_pkg and nms_ram.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+------------------------
//   input    | action_i, sample_value_i                  | in_valid_i / in_stall_o
//   output   | mean_value_o, out_row_o, out_col_o,       | out_valid_o / out_stall_i
//            | frame_last_o                              |
//   config   | cfg_index_i, cfg_data_i                   | cfg_valid_i / cfg_ready_o
//
// One request per clock while the pipeline does not stall. A result passes
// stages s1 to s4 and the output register after the request that completes
// its neighbourhood. Reset clears counters and valid bits; the line stores
// need no clearing. A stalled output holds while the stages before it keep
// taking requests until they fill. A config write restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_mean_smoother #(
  parameter int MAX_COLS    = nms_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = nms_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [nms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [nms_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               action_i,
  input  wire logic [SAMPLE_BITS-1:0]             sample_value_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [nms_pkg::MEAN_W-1:0]         mean_value_o,
  output logic      [nms_pkg::OUT_ROW_W-1:0]      out_row_o,
  output logic      [nms_pkg::OUT_COL_W-1:0]      out_col_o,
  output logic                                    frame_last_o
);

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CLAMP_W   = ($clog2(MAX_COLS + 1) > nms_pkg::NUM_COLS_W) ?
                             $clog2(MAX_COLS + 1) : nms_pkg::NUM_COLS_W;
  localparam int ROW_CNT_W = nms_pkg::ROW_CNT_W;
  localparam int OUT_ROW_W = nms_pkg::OUT_ROW_W;
  localparam int OUT_COL_W = nms_pkg::OUT_COL_W;
  localparam int MEAN_W    = nms_pkg::MEAN_W;
  localparam int SUM_W     = SAMPLE_BITS + 3;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int MW        = (SUM_W + FRAC_BITS > MEAN_W) ? SUM_W + FRAC_BITS : MEAN_W;

  localparam logic [SUM_W-1:0] RECIP3 = SUM_W'((64'd1 << SUM_W) / 3);
  localparam logic [SUM_W-1:0] RECIP5 = SUM_W'((64'd1 << SUM_W) / 5);
  localparam logic [MW-1:0]    FR31   = MW'((64'd1 << FRAC_BITS) / 3);
  localparam logic [MW-1:0]    FR32   = MW'((64'd2 << FRAC_BITS) / 3);
  localparam logic [MW-1:0]    FR51   = MW'((64'd1 << FRAC_BITS) / 5);
  localparam logic [MW-1:0]    FR52   = MW'((64'd2 << FRAC_BITS) / 5);
  localparam logic [MW-1:0]    FR53   = MW'((64'd3 << FRAC_BITS) / 5);
  localparam logic [MW-1:0]    FR54   = MW'((64'd4 << FRAC_BITS) / 5);
  localparam logic [MW-1:0]    MEAN_MAX = MW'({MEAN_W{1'b1}});

  // configuration and frame counters
  logic [OUT_ROW_W-1:0] rows_m1_q, rows_m1_d;
  logic [COL_W-1:0]     cols_m1_q, cols_m1_d;
  logic [ROW_CNT_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic                 in_done_q, in_done_d;

  logic                 cfg_we;
  logic [CLAMP_W-1:0]   cols_raw;
  logic                 in_accept;
  logic                 in_last_cell;
  logic                 has_out;
  logic                 out_last;
  logic [SAMPLE_BITS-1:0] sample_in;
  nms_pkg::meta_t       meta_in;

  // pipeline stage control
  logic take1, take2, take3, take4, take_o;

  logic                   s1_v_q;
  logic [COL_W-1:0]       s1_col_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  nms_pkg::meta_t         s1_meta_q;

  logic                   s2_v_q;
  logic [SAMPLE_BITS-1:0] s2_sample_q;
  logic [SAMPLE_BITS-1:0] s2_above_q;
  nms_pkg::meta_t         s2_meta_q;

  logic                   s3_v_q;
  logic [SUM_W-1:0]       s3_sum_q;
  nms_pkg::meta_t         s3_meta_q;

  logic                   s4_v_q;
  logic [SUM_W-1:0]       s4_sum_q;
  logic [SUM_W-1:0]       s4_quot_q;
  nms_pkg::meta_t         s4_meta_q;

  logic                   out_v_q;
  logic [MEAN_W-1:0]      mean_q;
  logic [OUT_ROW_W-1:0]   row_q;
  logic [OUT_COL_W-1:0]   col_q;
  logic                   last_q;

  logic [SAMPLE_BITS-1:0] above_rdata;
  logic [SAMPLE_BITS-1:0] top_rdata;

  logic [SAMPLE_BITS-1:0] win_lt_q, win_lm_q, win_lb_q;
  logic [SAMPLE_BITS-1:0] win_mt_q, win_mb_q, win_mm_q;
  logic [SUM_W-1:0]       sum_d;

  logic [PROD_W-1:0]      prod;

  logic [SUM_W-1:0]       q_x3, q_x5, rem0, rem_c, quot_c, div_const;
  logic [MW-1:0]          frac, mean_full;
  logic [MEAN_W-1:0]      mean_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign take_o     = !out_v_q || !out_stall_i;
  assign take4      = !s4_v_q || take_o;
  assign take3      = !s3_v_q || take4;
  assign take2      = !s2_v_q || take3;
  assign take1      = !s1_v_q || take2;
  assign in_stall_o = !take1;
  assign in_accept  = in_valid_i && take1;

  assign in_last_cell = (in_row_q == ROW_CNT_W'(rows_m1_q)) && (in_col_q == cols_m1_q);
  assign has_out      = (in_row_q != '0) &&
                        !((in_row_q == ROW_CNT_W'(1)) && (in_col_q == '0));
  assign out_last     = (out_row_q == rows_m1_q) && (out_col_q == cols_m1_q);
  assign sample_in    = (!action_i && !in_done_q) ? sample_value_i : '0;
  assign cols_raw     = CLAMP_W'(cfg_data_i[nms_pkg::NUM_COLS_W-1:0]);

  always_comb begin
    meta_in.has_out  = has_out;
    meta_in.last     = out_last;
    meta_in.top_ok   = (out_row_q != '0);
    meta_in.bot_ok   = (out_row_q != rows_m1_q);
    meta_in.left_ok  = (out_col_q != '0);
    meta_in.right_ok = (out_col_q != cols_m1_q);
    meta_in.row      = out_row_q;
    meta_in.col      = OUT_COL_W'(out_col_q);
    if ((out_row_q == '0 || out_row_q == rows_m1_q) &&
        (out_col_q == '0 || out_col_q == cols_m1_q)) begin
      meta_in.div = nms_pkg::DIV_BY_3;
    end else if (out_row_q == '0 || out_row_q == rows_m1_q ||
                 out_col_q == '0 || out_col_q == cols_m1_q) begin
      meta_in.div = nms_pkg::DIV_BY_5;
    end else begin
      meta_in.div = nms_pkg::DIV_BY_8;
    end
  end

  always_comb begin
    rows_m1_d = rows_m1_q;
    cols_m1_d = cols_m1_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    in_done_d = in_done_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        nms_pkg::REG_NUM_ROWS: begin
          if (cfg_data_i == '0) begin
            rows_m1_d = '0;
          end else if (cfg_data_i > nms_pkg::CFG_DATA_W'(nms_pkg::MAX_ROWS)) begin
            rows_m1_d = OUT_ROW_W'(nms_pkg::MAX_ROWS - 1);
          end else begin
            rows_m1_d = OUT_ROW_W'(cfg_data_i - nms_pkg::CFG_DATA_W'(1));
          end
        end
        nms_pkg::REG_NUM_COLS: begin
          if (cols_raw == '0) begin
            cols_m1_d = '0;
          end else if (cols_raw > CLAMP_W'(MAX_COLS)) begin
            cols_m1_d = COL_W'(MAX_COLS - 1);
          end else begin
            cols_m1_d = COL_W'(cols_raw - CLAMP_W'(1));
          end
        end
        default: begin
        end
      endcase
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
      in_done_d = 1'b0;
    end else if (in_accept) begin
      if (!in_done_q && in_last_cell) begin
        in_done_d = 1'b1;
      end
      if (in_col_q == cols_m1_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_CNT_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (has_out) begin
        if (out_last) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
          in_done_d = 1'b0;
        end else if (out_col_q == cols_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + OUT_ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q <= '0;
      cols_m1_q <= '0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      in_done_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      rows_m1_q <= rows_m1_d;
      cols_m1_q <= cols_m1_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      in_done_q <= in_done_d;
      if (take1) begin
        s1_v_q <= in_accept;
      end
      if (take2) begin
        s2_v_q <= s1_v_q;
      end
      if (take3) begin
        s3_v_q <= s2_v_q && s2_meta_q.has_out;
      end
      if (take4) begin
        s4_v_q <= s3_v_q;
      end
      if (take_o) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  nms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_above (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (in_col_q),
    .wdata_i (sample_in),
    .re_i    (in_accept),
    .raddr_i (in_col_q),
    .rdata_o (above_rdata)
  );

  nms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_top (
    .clk_i   (clk_i),
    .we_i    (take2 && s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (above_rdata),
    .re_i    (take2 && s1_v_q),
    .raddr_i (s1_col_q),
    .rdata_o (top_rdata)
  );

  always_comb begin
    sum_d = '0;
    if (s2_meta_q.left_ok) begin
      sum_d = sum_d + SUM_W'(win_lm_q);
      if (s2_meta_q.top_ok) begin
        sum_d = sum_d + SUM_W'(win_lt_q);
      end
      if (s2_meta_q.bot_ok) begin
        sum_d = sum_d + SUM_W'(win_lb_q);
      end
    end
    if (s2_meta_q.top_ok) begin
      sum_d = sum_d + SUM_W'(win_mt_q);
    end
    if (s2_meta_q.bot_ok) begin
      sum_d = sum_d + SUM_W'(win_mb_q);
    end
    if (s2_meta_q.right_ok) begin
      sum_d = sum_d + SUM_W'(s2_above_q);
      if (s2_meta_q.top_ok) begin
        sum_d = sum_d + SUM_W'(top_rdata);
      end
      if (s2_meta_q.bot_ok) begin
        sum_d = sum_d + SUM_W'(s2_sample_q);
      end
    end
  end

  assign prod = PROD_W'(s3_sum_q) *
                PROD_W'((s3_meta_q.div == nms_pkg::DIV_BY_5) ? RECIP5 : RECIP3);

  always_comb begin
    q_x3      = (s4_quot_q << 1) + s4_quot_q;
    q_x5      = (s4_quot_q << 2) + s4_quot_q;
    div_const = (s4_meta_q.div == nms_pkg::DIV_BY_5) ? SUM_W'(5) : SUM_W'(3);
    rem0      = s4_sum_q - ((s4_meta_q.div == nms_pkg::DIV_BY_5) ? q_x5 : q_x3);
    if (rem0 >= div_const) begin
      rem_c  = rem0 - div_const;
      quot_c = s4_quot_q + SUM_W'(1);
    end else begin
      rem_c  = rem0;
      quot_c = s4_quot_q;
    end
    frac = '0;
    case (s4_meta_q.div)
      nms_pkg::DIV_BY_3: begin
        case (rem_c[2:0])
          3'd1:    frac = FR31;
          3'd2:    frac = FR32;
          default: frac = '0;
        endcase
      end
      nms_pkg::DIV_BY_5: begin
        case (rem_c[2:0])
          3'd1:    frac = FR51;
          3'd2:    frac = FR52;
          3'd3:    frac = FR53;
          3'd4:    frac = FR54;
          default: frac = '0;
        endcase
      end
      default: frac = '0;
    endcase
    if (s4_meta_q.div == nms_pkg::DIV_BY_8) begin
      mean_full = (MW'(s4_sum_q) << FRAC_BITS) >> 3;
    end else begin
      mean_full = (MW'(quot_c) << FRAC_BITS) + frac;
    end
    if (mean_full > MEAN_MAX) begin
      mean_d = '1;
    end else begin
      mean_d = mean_full[MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q    <= in_col_q;
      s1_sample_q <= sample_in;
      s1_meta_q   <= meta_in;
    end
    if (take2 && s1_v_q) begin
      s2_sample_q <= s1_sample_q;
      s2_above_q  <= above_rdata;
      s2_meta_q   <= s1_meta_q;
    end
    if (take3 && s2_v_q) begin
      win_lt_q  <= win_mt_q;
      win_lm_q  <= win_mm_q;
      win_lb_q  <= win_mb_q;
      win_mt_q  <= top_rdata;
      win_mm_q  <= s2_above_q;
      win_mb_q  <= s2_sample_q;
      s3_sum_q  <= sum_d;
      s3_meta_q <= s2_meta_q;
    end
    if (take4 && s3_v_q) begin
      s4_sum_q  <= s3_sum_q;
      s4_quot_q <= prod[PROD_W-1:SUM_W];
      s4_meta_q <= s3_meta_q;
    end
    if (take_o && s4_v_q) begin
      mean_q <= mean_d;
      row_q  <= s4_meta_q.row;
      col_q  <= s4_meta_q.col;
      last_q <= s4_meta_q.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign mean_value_o = mean_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign frame_last_o = last_q;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for neighbour_mean_smoother: random raster frames go in through a
// queue-fed driver, results are checked against an in-bench 3x3 neighbor mean predictor.
// Depends on nms_pkg and the neighbour_mean_smoother top level.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_COLS    = nms_pkg::MAX_COLS_DEF;
  localparam int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_BITS   = nms_pkg::FRAC_BITS_DEF;
  localparam int RING_DEPTH  = 2 * MAX_COLS + 4;
  localparam longint MEAN_MAX = (longint'(1) << nms_pkg::MEAN_W) - 1;
  localparam int QUIET_LIMIT = 3000;
  localparam int PRESS_HOLD  = 250;
  localparam int RANDOM_REQS = 480;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_FLUSH  = 1'b1
  } pixel_action_e;

  typedef struct packed {
    pixel_action_e          action;
    logic [SAMPLE_BITS-1:0] value;
  } pixel_req_t;

  typedef struct packed {
    logic [nms_pkg::MEAN_W-1:0]    mean;
    logic [nms_pkg::OUT_ROW_W-1:0] row;
    logic [nms_pkg::OUT_COL_W-1:0] col;
    logic                          last;
  } mean_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready_o;
  logic [nms_pkg::CFG_IDX_W-1:0]  cfg_index = nms_pkg::REG_NUM_ROWS;
  logic [nms_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  logic                   action   = ACT_SAMPLE;
  logic [SAMPLE_BITS-1:0] sample   = '0;

  logic                          out_valid_o;
  logic                          out_stall = 1'b0;
  logic [nms_pkg::MEAN_W-1:0]    mean_value_o;
  logic [nms_pkg::OUT_ROW_W-1:0] out_row_o;
  logic [nms_pkg::OUT_COL_W-1:0] out_col_o;
  logic                          frame_last_o;

  neighbour_mean_smoother dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .action_i       (action),
    .sample_value_i (sample),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .mean_value_o   (mean_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .frame_last_o   (frame_last_o)
  );

  pixel_req_t   queued_pixels[$];
  mean_result_t pending_means[$];
  pixel_req_t   cur_req;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH] = '{default: '0};
  int rows_reg = 1;
  int cols_reg = 1;
  int in_row, in_col, out_row, out_col;

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit sending   = 1'b0;
  int send_wait, recv_wait, hold_left;
  int press_count, press_seen;
  int quiet_cycles;
  int fail_count, req_count, result_count, cfg_writes, settings_count;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(input int value, input int upper);
    if (value < 1) return 1;
    if (value > upper) return upper;
    return value;
  endfunction

  function automatic void restart_counts();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function automatic void smooth_step(input pixel_req_t req);
    int rows, cols, k, cells, r, c, rr, cc, div;
    longint sum, mean;
    bit row_rim, col_rim, last;
    mean_result_t res;
    rows  = clamp_dim(rows_reg, nms_pkg::MAX_ROWS);
    cols  = clamp_dim(cols_reg, MAX_COLS);
    k     = in_row * cols + in_col;
    cells = rows * cols;
    ring[k % RING_DEPTH] = (req.action == ACT_SAMPLE && k < cells) ? req.value : '0;
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    if (k < cols + 1) return;
    r   = out_row;
    c   = out_col;
    sum = 0;
    for (rr = r - 1; rr <= r + 1; rr++) begin
      for (cc = c - 1; cc <= c + 1; cc++) begin
        if (!(rr == r && cc == c) && rr >= 0 && cc >= 0 && rr < rows && cc < cols)
          sum += ring[(rr * cols + cc) % RING_DEPTH];
      end
    end
    row_rim = (r == 0) || (r == rows - 1);
    col_rim = (c == 0) || (c == cols - 1);
    div  = (row_rim && col_rim) ? 3 : ((row_rim || col_rim) ? 5 : 8);
    mean = (sum << FRAC_BITS) / div;
    if (mean > MEAN_MAX) mean = MEAN_MAX;
    last = (r == rows - 1) && (c == cols - 1);
    res.mean = mean[nms_pkg::MEAN_W-1:0];
    res.row  = r[nms_pkg::OUT_ROW_W-1:0];
    res.col  = c[nms_pkg::OUT_COL_W-1:0];
    res.last = last;
    pending_means.push_back(res);
    if (last) begin
      restart_counts();
    end else begin
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_BITS'(1000000);
      2: return '1;
      3: return SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
      4: return SAMPLE_BITS'($urandom());
      default: return SAMPLE_BITS'($urandom_range(0, 1000000));
    endcase
  endfunction

  function automatic void push_pixel(input pixel_action_e act, input logic [SAMPLE_BITS-1:0] v);
    pixel_req_t req;
    req.action = act;
    req.value  = v;
    queued_pixels.push_back(req);
  endfunction

  // cut < 0 sends the whole frame with its drain, otherwise only the first cut requests
  function automatic int queue_frame(input int rows, input int cols, input int cut);
    int n, total;
    pixel_action_e act;
    total = rows * cols + cols + 1;
    for (n = 0; n < total && (cut < 0 || n < cut); n++) begin
      if (n < rows * cols)
        act = ($urandom_range(0, 19) == 0) ? ACT_FLUSH : ACT_SAMPLE;
      else
        act = ($urandom_range(0, 5) == 0) ? ACT_SAMPLE : ACT_FLUSH;
      push_pixel(act, pick_sample());
    end
    return n;
  endfunction

  task automatic write_reg(input nms_pkg::cfg_reg_e idx, input int value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[nms_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == nms_pkg::REG_NUM_ROWS)
      rows_reg = value & 'h1FFF;
    else
      cols_reg = value & 'h7FF;
    restart_counts();
    cfg_writes++;
  endtask

  task automatic set_frame(input int rows_w, input int cols_w);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(nms_pkg::REG_NUM_ROWS, rows_w);
      write_reg(nms_pkg::REG_NUM_COLS, cols_w);
    end else begin
      write_reg(nms_pkg::REG_NUM_COLS, cols_w);
      write_reg(nms_pkg::REG_NUM_ROWS, rows_w);
    end
    send_calm <= ($urandom_range(0, 3) == 0);
    recv_calm <= ($urandom_range(0, 3) == 0);
    settings_count++;
  endtask

  task automatic settle();
    while (queued_pixels.size() != 0 || sending || pending_means.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : request_driver
    bit hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && !in_stall_o) begin
        smooth_step(cur_req);
        req_count++;
        hold = 1'b0;
        send_wait = send_calm ? 0 : $urandom_range(0, 15);
      end
      if (!hold) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (queued_pixels.size() > 0) begin
          cur_req = queued_pixels.pop_front();
          hold = 1'b1;
        end
      end
      sending = hold;
      in_valid <= hold;
      if (hold) begin
        action <= cur_req.action;
        sample <= cur_req.value;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    mean_result_t got, want;
    bit stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && !out_stall) begin
        got = '{mean_value_o, out_row_o, out_col_o, frame_last_o};
        result_count++;
        if (pending_means.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result at %0t: mean %0d row %0d col %0d last %0b",
                     $time, got.mean, got.row, got.col, got.last);
        end else begin
          want = pending_means.pop_front();
          if (got.mean !== want.mean || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at %0t: mean %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b",
                       $time, want.mean, got.mean, want.row, got.row,
                       want.col, got.col, want.last, got.last);
          end
        end
        recv_wait = recv_calm ? 0 : $urandom_range(0, 15);
      end
      if (press_count != press_seen) begin
        press_seen = press_count;
        hold_left  = PRESS_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall <= stall;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent, phase, rows_w, cols_w, rows, cols, frames, f, cut;
    restart_counts();
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // 3x3 frame: extreme values, flush inside the frame, sample during drain
    set_frame(3, 3);
    push_pixel(ACT_SAMPLE, '0);
    push_pixel(ACT_SAMPLE, '1);
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'(1000000));
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'(1));
    push_pixel(ACT_FLUSH, '1);
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'('hAAAAA));
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'('h55555));
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'(1000000));
    push_pixel(ACT_SAMPLE, '1);
    push_pixel(ACT_FLUSH, '0);
    push_pixel(ACT_SAMPLE, '1);
    push_pixel(ACT_FLUSH, '0);
    push_pixel(ACT_FLUSH, '0);
    settle();

    // zero registers act as a 1x1 frame
    set_frame(0, 0);
    push_pixel(ACT_SAMPLE, '1);
    push_pixel(ACT_FLUSH, '0);
    push_pixel(ACT_FLUSH, '0);
    settle();

    // single row
    set_frame(1, 3);
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'(1000000));
    push_pixel(ACT_SAMPLE, '1);
    push_pixel(ACT_SAMPLE, SAMPLE_BITS'(1000000));
    repeat (4) push_pixel(ACT_FLUSH, '0);
    settle();

    // oversized and maximum dimensions, start of frame only
    set_frame(8191, 1);
    void'(queue_frame(nms_pkg::MAX_ROWS, 1, 60));
    settle();
    set_frame(1, 2047);
    void'(queue_frame(1, MAX_COLS, 40));
    settle();
    set_frame(nms_pkg::MAX_ROWS, 2);
    void'(queue_frame(nms_pkg::MAX_ROWS, 2, 60));
    settle();
    set_frame(2, MAX_COLS);
    void'(queue_frame(2, MAX_COLS, 40));
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 7))
        0: rows_w = 0;
        1: rows_w = 1;
        2: rows_w = 2;
        default: rows_w = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
        0: cols_w = 0;
        1: cols_w = 1;
        2: cols_w = 2;
        default: cols_w = $urandom_range(1, 9);
      endcase
      if (phase == 1) begin
        rows_w = 4;
        cols_w = 8;
      end
      set_frame(rows_w, cols_w);
      rows = clamp_dim(rows_w, nms_pkg::MAX_ROWS);
      cols = clamp_dim(cols_w, MAX_COLS);
      if (phase == 1) begin
        @(posedge clk_i);
        send_calm   <= 1'b1;
        press_count <= press_count + 1;
      end
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rows * cols + cols) : -1;
        sent += queue_frame(rows, cols, cut);
        if (cut >= 0) break;
      end
      settle();
      phase++;
    end

    $display("covered %0d requests over %0d frame settings with %0d register writes",
             req_count, settings_count, cfg_writes);
    $display("checked %0d results, %0d failures", result_count, fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
